// ===== rtl/core/ship_pkg.sv =====
// Shared constants for the RRIP/signature replacement block.
// No dependencies.
package ship_pkg;
  localparam int SETS = 2048;
  localparam int WAYS = 16;
  localparam int SIG_COUNT = 64;
  localparam int HIST_LEN = 4;
  localparam int DECAY_LOG2 = 12;
  localparam int SET_W = $clog2(SETS);
  localparam int WAY_W = $clog2(WAYS);
  localparam int SIG_W = $clog2(SIG_COUNT);
  localparam int HP_W = $clog2(HIST_LEN);
  localparam int ROW_W = WAYS * 2;
  localparam logic [0:0] ACT_QUERY = 1'b0;
  localparam logic [0:0] REG_STREAM = 1'b0;
  localparam logic [0:0] REG_REUSE = 1'b1;
  localparam logic [1:0] RRPV_TOP = 2'd3;
  localparam logic [1:0] CTR_TOP = 2'd3;
endpackage

// ===== rtl/core/ship_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module ship_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/ship_scan.sv =====
// Victim search over one set, one way per cycle with a shared compare.
// Depends on ship_pkg.
module ship_scan (
  input  logic                        clk,
  input  logic                        start,
  input  logic [ship_pkg::ROW_W-1:0]  rrpv_row,
  input  logic [ship_pkg::ROW_W-1:0]  cnt_row,
  output logic                        done,
  output logic [ship_pkg::WAY_W-1:0]  victim
);
  import ship_pkg::*;
  logic                busy;
  logic [WAY_W-1:0]    idx;
  logic                zfound, tfound;
  logic [WAY_W-1:0]    zway, tway, hway;
  logic [2:0]          tcnt;
  logic [1:0]          htop;
  logic [1:0]          r, c;

  assign r = rrpv_row[idx*2 +: 2];
  assign c = cnt_row[idx*2 +: 2];

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (start) begin
      busy <= 1'b1; idx <= '0; zfound <= 1'b0; tfound <= 1'b0;
      tcnt <= 3'd4; htop <= 2'd0; zway <= '0; tway <= '0; hway <= '0;
    end else if (busy) begin
      if (r == RRPV_TOP && c == 2'd0 && !zfound) begin
        zfound <= 1'b1; zway <= idx;
      end
      if (r == RRPV_TOP && {1'b0, c} < tcnt) begin
        tcnt <= {1'b0, c}; tway <= idx; tfound <= 1'b1;
      end
      if (r > htop) begin
        htop <= r; hway <= idx;
      end
      idx <= idx + 1'b1;
      if (idx == WAY_W'(WAYS - 1)) begin
        busy <= 1'b0; done <= 1'b1;
      end
    end
  end

  always_comb begin
    if (zfound) victim = zway;
    else if (tfound) victim = tway;
    else victim = hway;
  end
endmodule

// ===== rtl/core/ship_rrip_stream_bypass_replacement.sv =====
// Top level: sequencer, set-row memories, stream tracker, predictor.
// Depends on ship_pkg, ship_ram, ship_scan.
//
// Usage: requests arrive on in_valid/in_ready with action, set_index, way,
// address, signature and hit; one response per request leaves on
// out_valid/out_ready with victim_way and bypassed. Registers are written on
// cfg_valid/cfg_ready (index 0 stream threshold, index 1 reuse threshold).
// After reset a clearing pass initializes every set row and the predictor;
// in_ready stays low meanwhile. A query raises out_valid after a row read,
// the start of the shared compare unit and 16 steps of that unit, one way
// per cycle. An update raises out_valid after a row read, then a modify and
// write step. Every 4096th update, after its write, runs a decay sweep over
// every set row, one set row per cycle, before its response is raised.
// The block takes one request at a time; a stalled response holds in the
// output register and blocks the next request until taken.
module ship_rrip_stream_bypass_replacement (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [ship_pkg::SET_W-1:0]    set_index,
  input  logic [ship_pkg::WAY_W-1:0]    way,
  input  logic [63:0]                   address,
  input  logic [ship_pkg::SIG_W-1:0]    signature,
  input  logic                          hit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ship_pkg::WAY_W-1:0]    victim_way,
  output logic                          bypassed,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [2:0]                    cfg_data
);
  import ship_pkg::*;

  localparam int HROW_W = 32 * HIST_LEN;
  localparam int SROW_W = SIG_W * WAYS;
  localparam int META_W = 64 + HP_W + 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_SCAN, S_UPD, S_DECAY, S_DRD, S_OUT
  } state_t;

  state_t             state;
  logic [SET_W-1:0]   sweep;
  logic [2:0]         thr_stream;
  logic [1:0]         thr_reuse;
  logic [DECAY_LOG2-1:0] upd_cnt;

  logic               q_act, q_hit;
  logic [SET_W-1:0]   q_set;
  logic [WAY_W-1:0]   q_way;
  logic [63:0]        q_addr;
  logic [SIG_W-1:0]   q_sig;
  logic [1:0]         q_pred;

  logic               we;
  logic [SET_W-1:0]   waddr, raddr;
  logic [ROW_W-1:0]   rrpv_w, rrpv_r, cnt_w, cnt_r;
  logic [SROW_W-1:0]  sig_w, sig_r;
  logic [HROW_W-1:0]  hist_w, hist_r;
  logic [META_W-1:0]  meta_w, meta_r;

  ship_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_rrpv (
    .clk, .we, .waddr, .wdata(rrpv_w), .raddr, .rdata(rrpv_r));
  ship_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_cnt (
    .clk, .we, .waddr, .wdata(cnt_w), .raddr, .rdata(cnt_r));
  ship_ram #(.WIDTH(SROW_W), .DEPTH(SETS)) u_sig (
    .clk, .we, .waddr, .wdata(sig_w), .raddr, .rdata(sig_r));
  ship_ram #(.WIDTH(HROW_W), .DEPTH(SETS)) u_hist (
    .clk, .we, .waddr, .wdata(hist_w), .raddr, .rdata(hist_r));
  ship_ram #(.WIDTH(META_W), .DEPTH(SETS)) u_meta (
    .clk, .we, .waddr, .wdata(meta_w), .raddr, .rdata(meta_r));

  logic               scan_start, scan_done;
  logic [WAY_W-1:0]   scan_victim;
  ship_scan u_scan (.clk, .start(scan_start), .rrpv_row(rrpv_r), .cnt_row(cnt_r),
    .done(scan_done), .victim(scan_victim));

  // update datapath
  logic [63:0]        last;
  logic [HP_W-1:0]    hp;
  logic               sflag, sflag_n, track;
  logic [31:0]        delta;
  logic [HROW_W-1:0]  hist_n;
  logic [HP_W:0]      match;
  logic [1:0]         c_old, c_new, r_new;
  logic [SIG_W-1:0]   old_sig;
  logic               byp;
  logic [ROW_W-1:0]   dec_row;

  // signature predictor
  logic               pred_we;
  logic [SIG_W-1:0]   pred_waddr, pred_raddr;
  logic [1:0]         pred_w, pred_r;

  ship_ram #(.WIDTH(2), .DEPTH(SIG_COUNT)) u_pred (
    .clk, .we(pred_we), .waddr(pred_waddr), .wdata(pred_w), .raddr(pred_raddr),
    .rdata(pred_r));

  assign last  = meta_r[META_W-1 -: 64];
  assign hp    = meta_r[1 +: HP_W];
  assign sflag = meta_r[0];
  assign track = (last != 64'd0);
  assign delta = q_addr[31:0] - last[31:0];
  assign c_old = cnt_r[q_way*2 +: 2];
  assign old_sig = sig_r[q_way*SIG_W +: SIG_W];
  assign pred_raddr = (state == S_IDLE) ? signature : old_sig;

  always_comb begin
    hist_n = hist_r;
    if (track) hist_n[hp*32 +: 32] = delta;
    match = '0;
    for (int i = 0; i < HIST_LEN; i++)
      if (hist_n[i*32 +: 32] == delta) match = match + 1'b1;
    sflag_n = track ? (match >= thr_stream) : sflag;
    byp = !q_hit && sflag_n;
    c_new = q_hit ? ((c_old < CTR_TOP) ? c_old + 2'd1 : c_old) : 2'd0;
    r_new = q_hit ? 2'd0 : ((q_pred >= thr_reuse) ? 2'd0 : RRPV_TOP);
    for (int i = 0; i < WAYS; i++)
      dec_row[i*2 +: 2] = (cnt_r[i*2 +: 2] != 2'd0) ? cnt_r[i*2 +: 2] - 2'd1 : 2'd0;
  end

  always_comb begin
    pred_we = 1'b0; pred_waddr = sweep[SIG_W-1:0]; pred_w = 2'd0;
    unique case (state)
      S_CLEAR: pred_we = 1'b1;
      S_UPD: begin
        pred_we = 1'b1;
        if (q_hit) begin
          pred_waddr = q_sig;
          pred_w = (q_pred < CTR_TOP) ? q_pred + 2'd1 : q_pred;
        end else begin
          pred_waddr = old_sig;
          pred_w = (pred_r != 2'd0) ? pred_r - 2'd1 : pred_r;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    we = 1'b0; waddr = sweep;
    rrpv_w = {WAYS{RRPV_TOP}}; cnt_w = '0; sig_w = '0; hist_w = '0; meta_w = '0;
    unique case (state)
      S_CLEAR: we = 1'b1;
      S_UPD: begin
        we = 1'b1; waddr = q_set;
        rrpv_w = rrpv_r; cnt_w = cnt_r; sig_w = sig_r; hist_w = hist_n;
        meta_w = {q_addr, track ? hp + 1'b1 : hp, sflag_n};
        if (!byp) begin
          rrpv_w[q_way*2 +: 2] = r_new;
          cnt_w[q_way*2 +: 2] = c_new;
          if (!q_hit) sig_w[q_way*SIG_W +: SIG_W] = q_sig;
        end
      end
      S_DECAY: begin
        we = 1'b1; waddr = sweep - 1'b1;
        rrpv_w = rrpv_r; cnt_w = dec_row; sig_w = sig_r; hist_w = hist_r; meta_w = meta_r;
      end
      default: ;
    endcase
  end

  assign raddr = (state == S_IDLE) ? set_index : (state == S_UPD || state == S_READ ||
                  state == S_SCAN) ? q_set : sweep;
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign scan_start = (state == S_READ) && (q_act == ACT_QUERY);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; sweep <= '0; out_valid <= 1'b0;
      thr_stream <= 3'd3; thr_reuse <= 2'd2; upd_cnt <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_STREAM) thr_stream <= cfg_data;
        else thr_reuse <= cfg_data[1:0];
      end
      unique case (state)
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == SET_W'(SETS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          q_act <= action; q_set <= set_index; q_way <= way; q_addr <= address;
          q_sig <= signature; q_hit <= hit; state <= S_READ;
        end
        S_READ: begin
          q_pred <= pred_r;
          state <= (q_act == ACT_QUERY) ? S_SCAN : S_UPD;
        end
        S_SCAN: if (scan_done) begin
          victim_way <= scan_victim; bypassed <= 1'b0; out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_UPD: begin
          victim_way <= '0; bypassed <= byp;
          out_valid <= (upd_cnt != '1);
          upd_cnt <= upd_cnt + 1'b1;
          sweep <= '0;
          state <= (upd_cnt == '1) ? S_DRD : S_OUT;
        end
        S_DRD: begin
          sweep <= sweep + 1'b1; state <= S_DECAY;
        end
        S_DECAY: begin
          sweep <= sweep + 1'b1;
          if (sweep == '0) begin
            out_valid <= 1'b1; state <= S_OUT;
          end
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ap_one_req: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("request taken while busy");
  ap_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("response dropped");
  ap_query_nobyp: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && scan_done) |=> !bypassed) else $error("query bypass");
  ap_busy_noin: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("ready while response pending");
endmodule
